>>> hw/rtl/gclf_pkg.sv
`timescale 1ns / 1ps

package gclf_pkg;

	localparam int LINE_W   = 31;
	localparam int XOR_W    = 7;
	localparam int PEND_W   = 5;
	localparam int CNT_W    = 5;
	localparam int DIG_N    = 10;
	localparam int DIG_W    = 4;
	localparam int UPC_W    = 5;
	localparam int SPACE_BUDGET = 16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW   = 8'h2A;
	localparam logic [7:0] CH_HIGH  = 8'h7A;

	localparam logic [UPC_W-1:0] PC_FETCH  = 5'd0;
	localparam logic [UPC_W-1:0] PC_HCONV  = 5'd3;
	localparam logic [UPC_W-1:0] PC_HDIG   = 5'd5;
	localparam logic [UPC_W-1:0] PC_BODY   = 5'd7;
	localparam logic [UPC_W-1:0] PC_FLUSH  = 5'd8;
	localparam logic [UPC_W-1:0] PC_UPDATE = 5'd9;
	localparam logic [UPC_W-1:0] PC_TAIL   = 5'd11;
	localparam logic [UPC_W-1:0] PC_TCONV  = 5'd14;
	localparam logic [UPC_W-1:0] PC_TDIG   = 5'd16;
	localparam logic [UPC_W-1:0] PC_END    = 5'd19;

	typedef enum logic [3:0] {
		A_NONE,
		A_FETCH,
		A_LOAD_LINE,
		A_LOAD_XOR,
		A_CONV,
		A_DIG_INIT,
		A_DIG,
		A_PREP,
		A_SPC,
		A_UPDATE,
		A_END
	} act_t;

	typedef enum logic [2:0] {
		SRC_SPACE,
		SRC_N,
		SRC_STAR,
		SRC_CR,
		SRC_LF,
		SRC_DIGIT,
		SRC_BYTE
	} src_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_HDR_DONE,
		C_CONV_MORE,
		C_DIG_MORE,
		C_NO_FLUSH,
		C_SPC_MORE,
		C_NO_KEEP,
		C_NOT_LAST
	} cond_t;

	typedef struct packed {
		logic             emit;
		src_t             src;
		act_t             act;
		cond_t            cond;
		logic [UPC_W-1:0] tgt;
	} ctl_t;

	typedef struct packed {
		logic hdr_done;
		logic conv_more;
		logic dig_more;
		logic no_flush;
		logic spc_more;
		logic no_keep;
		logic not_last;
	} flags_t;

	function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
		ctl_t w;
		w = '{1'b0, SRC_SPACE, A_NONE, C_NEVER, PC_FETCH};
		case (a)
			5'd0:  w = '{1'b0, SRC_SPACE, A_FETCH,     C_HDR_DONE,  PC_BODY};
			5'd1:  w = '{1'b1, SRC_SPACE, A_NONE,      C_NEVER,     PC_FETCH};
			5'd2:  w = '{1'b1, SRC_N,     A_LOAD_LINE, C_NEVER,     PC_FETCH};
			5'd3:  w = '{1'b0, SRC_SPACE, A_CONV,      C_CONV_MORE, PC_HCONV};
			5'd4:  w = '{1'b0, SRC_SPACE, A_DIG_INIT,  C_NEVER,     PC_FETCH};
			5'd5:  w = '{1'b1, SRC_DIGIT, A_DIG,       C_DIG_MORE,  PC_HDIG};
			5'd6:  w = '{1'b1, SRC_SPACE, A_NONE,      C_NEVER,     PC_FETCH};
			5'd7:  w = '{1'b0, SRC_SPACE, A_PREP,      C_NO_FLUSH,  PC_UPDATE};
			5'd8:  w = '{1'b1, SRC_SPACE, A_SPC,       C_SPC_MORE,  PC_FLUSH};
			5'd9:  w = '{1'b0, SRC_SPACE, A_UPDATE,    C_NO_KEEP,   PC_TAIL};
			5'd10: w = '{1'b1, SRC_BYTE,  A_NONE,      C_NEVER,     PC_FETCH};
			5'd11: w = '{1'b0, SRC_SPACE, A_NONE,      C_NOT_LAST,  PC_END};
			5'd12: w = '{1'b1, SRC_SPACE, A_NONE,      C_NEVER,     PC_FETCH};
			5'd13: w = '{1'b1, SRC_STAR,  A_LOAD_XOR,  C_NEVER,     PC_FETCH};
			5'd14: w = '{1'b0, SRC_SPACE, A_CONV,      C_CONV_MORE, PC_TCONV};
			5'd15: w = '{1'b0, SRC_SPACE, A_DIG_INIT,  C_NEVER,     PC_FETCH};
			5'd16: w = '{1'b1, SRC_DIGIT, A_DIG,       C_DIG_MORE,  PC_TDIG};
			5'd17: w = '{1'b1, SRC_CR,    A_NONE,      C_NEVER,     PC_FETCH};
			5'd18: w = '{1'b1, SRC_LF,    A_NONE,      C_NEVER,     PC_FETCH};
			5'd19: w = '{1'b0, SRC_SPACE, A_END,       C_ALWAYS,    PC_FETCH};
			default: w = '{1'b0, SRC_SPACE, A_END,     C_ALWAYS,    PC_FETCH};
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/gclf_seq.sv
`timescale 1ns / 1ps

module gclf_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  gclf_pkg::flags_t flags,
	output gclf_pkg::ctl_t  cw
);

	logic [gclf_pkg::UPC_W-1:0] upc_q;
	logic                       take;

	assign cw = gclf_pkg::ucode(upc_q);

	always_comb begin
		case (cw.cond)
			gclf_pkg::C_NEVER:     take = 1'b0;
			gclf_pkg::C_ALWAYS:    take = 1'b1;
			gclf_pkg::C_HDR_DONE:  take = flags.hdr_done;
			gclf_pkg::C_CONV_MORE: take = flags.conv_more;
			gclf_pkg::C_DIG_MORE:  take = flags.dig_more;
			gclf_pkg::C_NO_FLUSH:  take = flags.no_flush;
			gclf_pkg::C_SPC_MORE:  take = flags.spc_more;
			gclf_pkg::C_NO_KEEP:   take = flags.no_keep;
			gclf_pkg::C_NOT_LAST:  take = flags.not_last;
			default:               take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= gclf_pkg::PC_FETCH;
		end else if (go) begin
			upc_q <= take ? cw.tgt : upc_q + 1'b1;
		end
	end

endmodule

>>> hw/rtl/gclf_b2d.sv
`timescale 1ns / 1ps

module gclf_b2d (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  gclf_pkg::act_t                 act,
	input  logic [gclf_pkg::LINE_W-1:0]    line_val,
	input  logic [gclf_pkg::XOR_W-1:0]     xor_val,
	output logic                           conv_more,
	output logic                           dig_more,
	output logic [gclf_pkg::DIG_W-1:0]     digit
);

	logic [gclf_pkg::LINE_W-1:0]                       bin_q;
	logic [gclf_pkg::DIG_N-1:0][gclf_pkg::DIG_W-1:0]   bcd_q;
	logic [gclf_pkg::DIG_N-1:0][gclf_pkg::DIG_W-1:0]   adj;
	logic [gclf_pkg::DIG_N*gclf_pkg::DIG_W-1:0]        adj_flat;
	logic [gclf_pkg::CNT_W-1:0]                        cnt_q;
	logic [gclf_pkg::DIG_W-1:0]                        dig_q;
	logic [gclf_pkg::DIG_W-1:0]                        lead;

	always_comb begin
		for (int i = 0; i < gclf_pkg::DIG_N; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign adj_flat = adj;

	always_comb begin
		lead = '0;
		for (int i = 0; i < gclf_pkg::DIG_N; i++) begin
			if (bcd_q[i] != '0) begin
				lead = gclf_pkg::DIG_W'(i);
			end
		end
	end

	assign conv_more = (cnt_q != 5'd1);
	assign dig_more  = (dig_q != '0);
	assign digit     = bcd_q[dig_q];

	always_ff @(posedge clk) begin
		if (go) begin
			case (act)
				gclf_pkg::A_LOAD_LINE: begin
					bin_q <= line_val;
					bcd_q <= '0;
				end
				gclf_pkg::A_LOAD_XOR: begin
					bin_q <= {xor_val, (gclf_pkg::LINE_W - gclf_pkg::XOR_W)'(0)};
					bcd_q <= '0;
				end
				gclf_pkg::A_CONV: begin
					bin_q <= {bin_q[gclf_pkg::LINE_W-2:0], 1'b0};
					bcd_q <= {adj_flat[gclf_pkg::DIG_N*gclf_pkg::DIG_W-2:0],
						bin_q[gclf_pkg::LINE_W-1]};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dig_q <= '0;
		end else if (go) begin
			case (act)
				gclf_pkg::A_LOAD_LINE: cnt_q <= gclf_pkg::CNT_W'(gclf_pkg::LINE_W);
				gclf_pkg::A_LOAD_XOR:  cnt_q <= gclf_pkg::CNT_W'(gclf_pkg::XOR_W);
				gclf_pkg::A_CONV:      cnt_q <= cnt_q - 1'b1;
				gclf_pkg::A_DIG_INIT:  dig_q <= lead;
				gclf_pkg::A_DIG:       dig_q <= dig_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/gclf_out.sv
`timescale 1ns / 1ps

module gclf_out (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] push_byte,
	input  logic       push_ll,
	input  logic       fin,
	output logic       busy,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       line_last,
	output logic       out_valid,
	input  logic       out_ready
);

	logic [7:0] hold_q;
	logic       hold_ll_q;
	logic       hold_v_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       rl_q;
	logic       ll_q;
	logic       load;

	assign busy      = hold_v_q && ov_q && !out_ready;
	assign load      = (push || fin) && hold_v_q;
	assign out_byte  = ob_q;
	assign run_last  = rl_q;
	assign line_last = ll_q;
	assign out_valid = ov_q;

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q    <= push_byte;
			hold_ll_q <= push_ll;
		end
		if (load) begin
			ob_q <= hold_q;
			rl_q <= fin;
			ll_q <= fin && hold_ll_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (push) begin
				hold_v_q <= 1'b1;
			end else if (fin) begin
				hold_v_q <= 1'b0;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!ov_q || out_ready))
		else $error("Held byte moved onto an output that has not transferred.");

	a_fin_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !hold_v_q)
		else $error("Hold stage still full after the end of a step.");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> hold_v_q)
		else $error("Hold stage empty after a byte was pushed.");

endmodule

>>> hw/rtl/gcode_line_framer_unit.sv
`timescale 1ns / 1ps
// Each emitted byte enters a hold stage and moves to the output register with the next push
// or at the end of the step; the input is taken again only at the fetch step.
// The sequencer stalls an emitting step while the output is held up; the first item of a line
// adds a 31-step decimal pass on the line number, the last item a pass on the checksum.
// Each emitted byte costs one microcode step; the shared decimal unit sets the long steps.
// Reset clears the sequencer, the line state and both output stages; no clearing pass.

module gcode_line_framer_unit #(
	parameter int MAX_PENDING_SPACES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        byte_valid,
	input  logic [gclf_pkg::LINE_W-1:0] line_number,
	input  logic                        end_of_command,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        run_last,
	output logic                        line_last
);

	gclf_pkg::ctl_t   cw;
	gclf_pkg::flags_t flags;

	logic [7:0]                  byte_q;
	logic                        bval_q;
	logic [gclf_pkg::LINE_W-1:0] line_q;
	logic                        last_q;

	logic                         in_line_q;
	logic                         cmt_q;
	logic [gclf_pkg::PEND_W-1:0]  pend_q;
	logic [gclf_pkg::XOR_W-1:0]   xor_q;
	logic                         xstop_q;
	logic [gclf_pkg::PEND_W-1:0]  spc_q;

	logic                        accept;
	logic                        busy;
	logic                        go;
	logic                        push;
	logic                        fin;
	logic [7:0]                  push_byte;
	logic [gclf_pkg::DIG_W-1:0]  digit;
	logic                        conv_more;
	logic                        dig_more;
	logic                        proc_b;
	logic                        other_b;
	logic                        keep_b;

	assign in_ready = (cw.act == gclf_pkg::A_FETCH);
	assign accept   = in_valid && in_ready;
	assign go       = in_ready ? in_valid : !((cw.emit || cw.act == gclf_pkg::A_END) && busy);
	assign push     = go && cw.emit;
	assign fin      = go && (cw.act == gclf_pkg::A_END);

	always_comb begin
		proc_b  = bval_q && !cmt_q;
		other_b = proc_b && (byte_q != gclf_pkg::CH_SEMI) && (byte_q != gclf_pkg::CH_SPACE);
		keep_b  = other_b && (byte_q inside {[gclf_pkg::CH_LOW:gclf_pkg::CH_HIGH]});
	end

	always_comb begin
		flags.hdr_done  = in_line_q;
		flags.conv_more = conv_more;
		flags.dig_more  = dig_more;
		flags.no_flush  = !(other_b && pend_q != '0);
		flags.spc_more  = (spc_q != 5'd1);
		flags.no_keep   = !keep_b;
		flags.not_last  = !last_q;
	end

	always_comb begin
		case (cw.src)
			gclf_pkg::SRC_SPACE: push_byte = gclf_pkg::CH_SPACE;
			gclf_pkg::SRC_N:     push_byte = gclf_pkg::CH_N;
			gclf_pkg::SRC_STAR:  push_byte = gclf_pkg::CH_STAR;
			gclf_pkg::SRC_CR:    push_byte = gclf_pkg::CH_CR;
			gclf_pkg::SRC_LF:    push_byte = gclf_pkg::CH_LF;
			gclf_pkg::SRC_DIGIT: push_byte = gclf_pkg::CH_ZERO | {4'h0, digit};
			gclf_pkg::SRC_BYTE:  push_byte = byte_q;
			default:             push_byte = gclf_pkg::CH_SPACE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
			bval_q <= byte_valid;
			line_q <= line_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			in_line_q <= 1'b0;
			cmt_q     <= 1'b0;
			pend_q    <= '0;
			xor_q     <= '0;
			xstop_q   <= 1'b0;
			spc_q     <= '0;
		end else begin
			if (accept) begin
				last_q    <= end_of_command;
				in_line_q <= 1'b1;
			end
			if (push && !xstop_q) begin
				if (push_byte == gclf_pkg::CH_STAR) begin
					xstop_q <= 1'b1;
				end else begin
					xor_q <= xor_q ^ push_byte[gclf_pkg::XOR_W-1:0];
				end
			end
			if (go) begin
				case (cw.act)
					gclf_pkg::A_PREP: begin
						spc_q <= (pend_q > gclf_pkg::PEND_W'(gclf_pkg::SPACE_BUDGET)) ?
							gclf_pkg::PEND_W'(gclf_pkg::SPACE_BUDGET) : pend_q;
					end
					gclf_pkg::A_SPC: spc_q <= spc_q - 1'b1;
					gclf_pkg::A_UPDATE: begin
						if (proc_b) begin
							if (byte_q == gclf_pkg::CH_SEMI) begin
								cmt_q <= 1'b1;
							end else if (byte_q == gclf_pkg::CH_SPACE) begin
								if (pend_q < gclf_pkg::PEND_W'(MAX_PENDING_SPACES)) begin
									pend_q <= pend_q + 1'b1;
								end
							end else begin
								pend_q <= '0;
							end
						end
					end
					gclf_pkg::A_END: begin
						if (last_q) begin
							in_line_q <= 1'b0;
							cmt_q     <= 1'b0;
							pend_q    <= '0;
							xor_q     <= '0;
							xstop_q   <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	gclf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.flags  (flags),
		.cw     (cw)
	);

	gclf_b2d u_b2d (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.act       (cw.act),
		.line_val  (line_q),
		.xor_val   (xor_q),
		.conv_more (conv_more),
		.dig_more  (dig_more),
		.digit     (digit)
	);

	gclf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_byte (push_byte),
		.push_ll   (cw.src == gclf_pkg::SRC_LF),
		.fin       (fin),
		.busy      (busy),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.line_last (line_last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	a_line_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_last |-> run_last)
		else $error("Line end marked on a byte that does not end its run.");

	a_fetch_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("Sequencer still fetching after an input transfer.");

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		push && cw.src == gclf_pkg::SRC_DIGIT |-> digit <= 4'd9)
		else $error("Decimal unit produced a digit above nine.");

	a_xor_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		xstop_q && !fin |=> xstop_q && $stable(xor_q))
		else $error("Checksum changed after the first star.");

endmodule

>>> tb/gcode_line_framer_unit_tb.sv
`timescale 1ns / 1ps

module gcode_line_framer_unit_tb;
	import gclf_pkg::*;

	localparam int MAX_PEND    = 16;
	localparam int MAX_RESULTS = 24;
	localparam int DIR_ROWS    = 25;
	localparam logic [30:0] LINE_MAX = 31'h7FFFFFFF;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       line_last;
	} frame_byte_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        bv;
		logic [30:0] ln;
		logic        eoc;
		logic [4:0]  reps;
		logic        typed;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic [30:0] line_number = '0;
	logic        end_of_command = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        line_last;

	frame_byte_t exp_frame [$];
	frame_byte_t step_out [$];

	logic            st_in_line = 1'b0;
	logic            st_comment = 1'b0;
	logic [4:0]      st_pend = '0;
	logic [6:0]      st_xor = '0;
	logic            st_xor_frozen = 1'b0;

	int send_idle_pct = 35;
	int recv_idle_pct = 73;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int items_sent = 0;
	int mismatch_cnt = 0;

	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{8'h00,    1'b0, 31'd0,     1'b1, 5'd1,  1'b1},
		'{"G",      1'b1, LINE_MAX,  1'b0, 5'd1,  1'b0},
		'{"1",      1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{CH_SPACE, 1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{8'h00,    1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{8'hFF,    1'b1, LINE_MAX,  1'b0, 5'd1,  1'b1},
		'{8'h29,    1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{CH_STAR,  1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{CH_HIGH,  1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{8'h7B,    1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{"X",      1'b0, 31'd0,     1'b0, 5'd1,  1'b1},
		'{CH_SPACE, 1'b1, 31'd0,     1'b0, 5'd17, 1'b1},
		'{"A",      1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{CH_SPACE, 1'b1, 31'd0,     1'b0, 5'd2,  1'b1},
		'{CH_SEMI,  1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{"Q",      1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{CH_SPACE, 1'b1, 31'd0,     1'b1, 5'd1,  1'b0},
		'{CH_SPACE, 1'b1, 31'd5,     1'b0, 5'd1,  1'b0},
		'{CH_SPACE, 1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{"M",      1'b1, 31'd0,     1'b0, 5'd1,  1'b1},
		'{8'h00,    1'b0, 31'd0,     1'b1, 5'd1,  1'b0},
		'{"G",      1'b1, 31'd12345, 1'b1, 5'd1,  1'b0},
		'{8'h80,    1'b1, 31'd7,     1'b0, 5'd1,  1'b0},
		'{CH_SPACE, 1'b1, 31'd0,     1'b0, 5'd16, 1'b1},
		'{"x",      1'b1, 31'd0,     1'b1, 5'd1,  1'b0}
	};

	string dir_text [0:DIR_ROWS-1] = '{
		" N0  *94\r\n", "", "1", "", " ", "", "", "*", "z", "", "", "",
		"                A", "", "", "", "", "", "", "  M", "", "", "", "", ""
	};

	gcode_line_framer_unit #(
		.MAX_PENDING_SPACES(MAX_PEND)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.byte_valid     (byte_valid),
		.line_number    (line_number),
		.end_of_command (end_of_command),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.line_last      (line_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic emit_byte(input logic [7:0] b);
		if (step_out.size() >= MAX_RESULTS) begin
			return;
		end
		step_out.push_back('{b, 1'b0, 1'b0});
		if (!st_xor_frozen) begin
			if (b == CH_STAR) begin
				st_xor_frozen = 1'b1;
			end else begin
				st_xor = st_xor ^ b[6:0];
			end
		end
	endtask

	task automatic emit_decimal(input logic [31:0] v);
		logic [3:0] dig [0:9];
		int k;
		k = 0;
		do begin
			dig[k] = 4'(v % 10);
			v = v / 10;
			k++;
		end while (v != 0 && k < 10);
		for (int i = k - 1; i >= 0; i--) begin
			emit_byte(CH_ZERO + 8'(dig[i]));
		end
	endtask

	task automatic frame_step(input logic [7:0] b, input logic bv, input logic [30:0] ln,
			input logic eoc);
		int n;
		step_out.delete();
		if (!st_in_line) begin
			st_in_line = 1'b1;
			emit_byte(CH_SPACE);
			emit_byte(CH_N);
			emit_decimal({1'b0, ln});
			emit_byte(CH_SPACE);
		end
		if (bv && !st_comment) begin
			if (b == CH_SEMI) begin
				st_comment = 1'b1;
			end else if (b == CH_SPACE) begin
				if (st_pend < MAX_PEND) begin
					st_pend = st_pend + 5'd1;
				end
			end else begin
				n = (st_pend > SPACE_BUDGET) ? SPACE_BUDGET : int'(st_pend);
				repeat (n) emit_byte(CH_SPACE);
				st_pend = '0;
				if (b >= CH_LOW && b <= CH_HIGH) begin
					emit_byte(b);
				end
			end
		end
		if (eoc) begin
			st_pend = '0;
			emit_byte(CH_SPACE);
			emit_byte(CH_STAR);
			emit_decimal({25'd0, st_xor});
			emit_byte(CH_CR);
			emit_byte(CH_LF);
			if (step_out.size() > 0) begin
				step_out[step_out.size() - 1].line_last = 1'b1;
			end
			st_in_line = 1'b0;
			st_comment = 1'b0;
			st_xor = '0;
			st_xor_frozen = 1'b0;
		end
		if (step_out.size() > 0) begin
			step_out[step_out.size() - 1].run_last = 1'b1;
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic bv, input logic [30:0] ln,
			input logic eoc, input logic typed, input string text);
		int len;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		byte_valid <= bv;
		line_number <= ln;
		end_of_command <= eoc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		frame_step(b, bv, ln, eoc);
		if (typed) begin
			len = text.len();
			for (int i = 0; i < len; i++) begin
				exp_frame.push_back('{text[i], i == len - 1, eoc && (i == len - 1)});
			end
		end else begin
			foreach (step_out[i]) exp_frame.push_back(step_out[i]);
		end
		items_sent++;
	endtask

	task automatic send_random_line();
		string gchars;
		int len;
		int sel;
		logic [30:0] ln;
		logic [7:0] b;
		logic bv;
		gchars = "GMTXYZEFS0123456789.-";
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			ln = '0;
		end else if (sel == 1) begin
			ln = LINE_MAX;
		end else if (sel < 4) begin
			ln = 31'($urandom);
		end else begin
			ln = 31'($urandom_range(0, 9999));
		end
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 24) == 0 && n < len - 1) begin
				repeat ($urandom_range(17, 20)) send_item(CH_SPACE, 1'b1, ln, 1'b0, 1'b0, "");
			end
			sel = $urandom_range(0, 99);
			bv = 1'b1;
			if (sel < 45) begin
				b = gchars[$urandom_range(0, gchars.len() - 1)];
			end else if (sel < 65) begin
				b = CH_SPACE;
			end else if (sel < 69) begin
				b = CH_SEMI;
			end else if (sel < 80) begin
				b = 8'($urandom_range(0, 255));
			end else if (sel < 86) begin
				b = 8'($urandom_range(CH_LOW, CH_HIGH));
			end else if (sel < 91) begin
				b = 8'($urandom_range(0, 255));
				bv = 1'b0;
			end else if (sel < 95) begin
				b = CH_STAR;
			end else begin
				b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, CH_LOW - 1))
					: 8'($urandom_range(CH_HIGH + 1, 255));
			end
			send_item(b, bv, ln, n == len - 1, 1'b0, "");
		end
	endtask

	task automatic wait_drained();
		while (exp_frame.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = 600;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (exp_frame.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) begin
					$display("unexpected transfer: byte %h run_last %b line_last %b",
						out_byte, run_last, line_last);
				end
			end else begin
				want = exp_frame.pop_front();
				if (out_byte !== want.data || run_last !== want.run_last ||
						line_last !== want.line_last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("mismatch: expected byte %h run_last %b line_last %b, got %h %b %b",
							want.data, want.run_last, want.line_last,
							out_byte, run_last, line_last);
					end
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			repeat (dir_rows[r].reps) begin
				send_item(dir_rows[r].b, dir_rows[r].bv, dir_rows[r].ln, dir_rows[r].eoc,
					dir_rows[r].typed, dir_text[r]);
			end
		end
		while (items_sent < 150) send_random_line();

		// The sender stops here until every framed byte so far has come out.
		in_valid <= 1'b0;
		wait_drained();
		send_idle_pct = 73;
		recv_idle_pct = 35;
		while (items_sent < 265) send_random_line();

		in_valid <= 1'b0;
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// A long output stall with the sender still offering fills the block.
		hold_req++;
		while (items_sent < 385) send_random_line();

		in_valid <= 1'b0;
		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatch_cnt == 0 && exp_frame.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
